// ----- rtl/core/macrotile_cursor_address_gen_unit_macros.svh -----
// ----------------------------------------------------------------------------
// macrotile cursor address generator: assertion macros
// concurrent checks sampled on the rising clock edge, off while reset is high
// ----------------------------------------------------------------------------
`ifndef MACROTILE_CURSOR_ADDRESS_GEN_UNIT_MACROS_SVH
`define MACROTILE_CURSOR_ADDRESS_GEN_UNIT_MACROS_SVH

// same-cycle implication
`define MCAG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MCAG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/mcag_pkg.sv -----
// ----------------------------------------------------------------------------
// mcag_pkg
// widths, codes and helpers shared by the macrotile cursor address generator
// ----------------------------------------------------------------------------
`default_nettype none

package mcag_pkg;

   localparam int ADDR_W           = 12;
   localparam int STORE_DEPTH      = 4096;
   localparam int ID_W             = 8;
   localparam int COORD_W          = 8;
   localparam int INDEX_W          = 12;
   localparam int OFS_W            = 2;
   localparam int QUOT_W           = 7;
   localparam int MAP_COLS_DEFAULT = 64;
   localparam int GROUP_SIDE       = 3;

   // reciprocal of three, exact for every 8-bit coordinate
   localparam int RECIP3_MUL   = 171;
   localparam int RECIP3_SHIFT = 9;
   localparam int RECIP3_W     = COORD_W + RECIP3_SHIFT;

   typedef enum logic [1:0] {
      MODE_WRITE = 2'd0,
      MODE_SEEK  = 2'd1,
      MODE_RIGHT = 2'd2,
      MODE_DOWN  = 2'd3
   } mode_type;

   function automatic logic [QUOT_W-1:0] div3(input logic [COORD_W-1:0] x);
      logic [RECIP3_W-1:0] prod;
      prod = RECIP3_W'(x) * RECIP3_W'(RECIP3_MUL);
      return QUOT_W'(prod >> RECIP3_SHIFT);
   endfunction

   function automatic logic [OFS_W-1:0] rem3(input logic [COORD_W-1:0] x,
                                              input logic [QUOT_W-1:0]  q);
      logic [COORD_W-1:0] three_q;
      three_q = COORD_W'({q, 1'b0}) + COORD_W'(q);
      return OFS_W'(x - three_q);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mcag_ram.sv -----
// ----------------------------------------------------------------------------
// mcag_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mcag_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/macrotile_cursor_address_gen_unit.sv -----
// ----------------------------------------------------------------------------
// macrotile_cursor_address_gen_unit
// tile cursor over a map of 3x3 macrotiles, answering tile index per move
// ----------------------------------------------------------------------------
// A write beat stores a macrotile id in the map; it gives no result and is
// taken even while a result waits on the output. A step that stays inside
// the current macrotile answers in the cycle after it is taken. A step that
// crosses into the next macrotile first reads the id store, whose read is
// registered. A seek first splits x,y into macrotile and offset, then forms
// the map address and reads the store, then turns the id into the tile
// index. The id store has no reset; a map entry must be written before a
// seek or step reads it. The cursor starts at map address zero, offset zero.
`default_nettype none

module macrotile_cursor_address_gen_unit #(
   parameter int MAP_COLS = mcag_pkg::MAP_COLS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [1:0]                     req_mode,
   input  wire logic [mcag_pkg::COORD_W-1:0]   req_tile_x,
   input  wire logic [mcag_pkg::COORD_W-1:0]   req_tile_y,
   input  wire logic [mcag_pkg::ADDR_W-1:0]    req_entry_addr,
   input  wire logic [mcag_pkg::ID_W-1:0]      req_entry_id,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [mcag_pkg::INDEX_W-1:0]   rsp_tile_index
);

   localparam int ADDR_W  = mcag_pkg::ADDR_W;
   localparam int INDEX_W = mcag_pkg::INDEX_W;
   localparam int OFS_W   = mcag_pkg::OFS_W;
   localparam int QUOT_W  = mcag_pkg::QUOT_W;
   localparam int ID_W    = mcag_pkg::ID_W;
   localparam logic [OFS_W-1:0] OFS_LAST = OFS_W'(mcag_pkg::GROUP_SIDE - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEEK,
      ST_FETCH
   } state_type;

   function automatic logic [INDEX_W-1:0] cell_index(input logic [INDEX_W-1:0] base,
                                                     input logic [OFS_W-1:0]   row,
                                                     input logic [OFS_W-1:0]   col);
      logic [INDEX_W-1:0] row3;
      row3 = INDEX_W'({row, 1'b0}) + INDEX_W'(row);
      return base + row3 + INDEX_W'(col);
   endfunction

   state_type            state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [ADDR_W-1:0]    cursor_ff, cursor_in;
   logic [OFS_W-1:0]     col_ff, col_in;
   logic [OFS_W-1:0]     row_ff, row_in;
   logic [INDEX_W-1:0]   base_ff, base_in;
   logic [QUOT_W-1:0]    qx_ff, qx_in;
   logic [QUOT_W-1:0]    qy_ff, qy_in;

   logic                 accept;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ID_W-1:0]      rd_data;
   logic                 wr_en;
   logic [ADDR_W-1:0]    seek_addr;
   logic [ADDR_W-1:0]    right_addr;
   logic [ADDR_W-1:0]    down_addr;
   logic [INDEX_W-1:0]   fetched_base;
   mcag_pkg::mode_type   mode;

   assign mode      = mcag_pkg::mode_type'(req_mode);
   // a write never touches the output register, so only result beats wait on it
   assign req_stall = (state_ff != ST_IDLE) ||
                      (rsp_valid_ff && rsp_stall && (mode != mcag_pkg::MODE_WRITE));
   assign accept    = req_valid && !req_stall;

   assign seek_addr    = ADDR_W'(qy_ff) * ADDR_W'(MAP_COLS) + ADDR_W'(qx_ff);
   assign right_addr   = cursor_ff + ADDR_W'(1);
   assign down_addr    = cursor_ff + ADDR_W'(MAP_COLS);
   assign fetched_base = INDEX_W'({rd_data, 3'b000}) + INDEX_W'(rd_data);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_index_in = rsp_index_ff;
      cursor_in    = cursor_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      base_in      = base_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      rd_en        = 1'b0;
      rd_addr      = cursor_ff;
      wr_en        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (mode)
                  mcag_pkg::MODE_WRITE: begin
                     wr_en = 1'b1;
                  end
                  mcag_pkg::MODE_SEEK: begin
                     qx_in    = mcag_pkg::div3(req_tile_x);
                     qy_in    = mcag_pkg::div3(req_tile_y);
                     col_in   = mcag_pkg::rem3(req_tile_x, qx_in);
                     row_in   = mcag_pkg::rem3(req_tile_y, qy_in);
                     state_in = ST_SEEK;
                  end
                  mcag_pkg::MODE_RIGHT: begin
                     if (col_ff == OFS_LAST) begin
                        col_in    = '0;
                        cursor_in = right_addr;
                        rd_en     = 1'b1;
                        rd_addr   = right_addr;
                        state_in  = ST_FETCH;
                     end else begin
                        col_in       = col_ff + OFS_W'(1);
                        rsp_valid_in = 1'b1;
                        rsp_index_in = cell_index(base_ff, row_ff, col_in);
                     end
                  end
                  mcag_pkg::MODE_DOWN: begin
                     if (row_ff == OFS_LAST) begin
                        row_in    = '0;
                        cursor_in = down_addr;
                        rd_en     = 1'b1;
                        rd_addr   = down_addr;
                        state_in  = ST_FETCH;
                     end else begin
                        row_in       = row_ff + OFS_W'(1);
                        rsp_valid_in = 1'b1;
                        rsp_index_in = cell_index(base_ff, row_in, col_ff);
                     end
                  end
               endcase
            end
         end
         ST_SEEK: begin
            cursor_in = seek_addr;
            rd_en     = 1'b1;
            rd_addr   = seek_addr;
            state_in  = ST_FETCH;
         end
         ST_FETCH: begin
            base_in      = fetched_base;
            rsp_valid_in = 1'b1;
            rsp_index_in = cell_index(fetched_base, row_ff, col_ff);
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cursor_ff    <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         base_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         base_ff      <= base_in;
      end
      rsp_index_ff <= rsp_index_in;
      qx_ff        <= qx_in;
      qy_ff        <= qy_in;
   end

   mcag_ram #(
      .WIDTH (ID_W),
      .DEPTH (mcag_pkg::STORE_DEPTH)
   ) u_id_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_entry_addr),
      .wr_data (req_entry_id),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tile_index = rsp_index_ff;

`include "macrotile_cursor_address_gen_unit_macros.svh"

   // while a seek or fetch is in flight the output register must be empty
   `MCAG_ASSERT_NOW(a_busy_rsp_empty, clock, reset, state_ff != ST_IDLE, !rsp_valid_ff, "result register busy during fetch")
   `MCAG_ASSERT_NOW(a_busy_stalls, clock, reset, state_ff != ST_IDLE, req_stall, "request taken during fetch")
   `MCAG_ASSERT_NOW(a_offsets_in_cell, clock, reset, 1'b1, (col_ff != 2'd3) && (row_ff != 2'd3), "cell offset out of macrotile")
   `MCAG_ASSERT_NEXT(a_write_no_result, clock, reset, accept && (mode == mcag_pkg::MODE_WRITE) && !rsp_valid_ff, !rsp_valid_ff && (state_ff == ST_IDLE), "map write produced a result")

endmodule

`default_nettype wire
